>>> hw/rtl/imu_bias_calibration_smoother_assert.svh
// Assertion macros used by the calibration sequencer (imubc_cal).
// IMP checks a same-cycle implication, NXT checks the following cycle.
`ifndef IMU_BIAS_CALIBRATION_SMOOTHER_ASSERT_SVH
`define IMU_BIAS_CALIBRATION_SMOOTHER_ASSERT_SVH

`define IMUBC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imubc assertion failed");

`define IMUBC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imubc assertion failed");

`endif

>>> hw/rtl/imubc_pkg.sv
// ----------------------------------------------------------------------------
// imubc_pkg
// Types and constants of the IMU bias calibration smoother.
// ----------------------------------------------------------------------------
package imubc_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned KEEP_W     = 16;
  localparam int unsigned BAND_W     = 8;
  localparam int unsigned NEEDED_W   = 8;
  localparam int unsigned DISCARD_W  = 10;
  localparam int unsigned GRAV_W     = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_KEEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_BAND     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_QUIET_NEEDED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCARD_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY_REF    = 3'd4;

  // register reset values
  localparam logic [KEEP_W-1:0]    RST_SMOOTHING_KEEP = 16'd55706;
  localparam logic [BAND_W-1:0]    RST_QUIET_BAND     = 8'd5;
  localparam logic [NEEDED_W-1:0]  RST_QUIET_NEEDED   = 8'd30;
  localparam logic [DISCARD_W-1:0] RST_DISCARD_COUNT  = 10'd100;
  localparam logic [GRAV_W-1:0]    RST_GRAVITY_REF    = 15'd16384;

  // command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_START  = 1'b1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [KEEP_W-1:0]    smoothing_keep;
    logic [BAND_W-1:0]    quiet_band;
    logic [NEEDED_W-1:0]  quiet_needed;
    logic [DISCARD_W-1:0] discard_count;
    logic [GRAV_W-1:0]    gravity_ref;
  } imubc_cfg_t;

  // one word leaving the input register this cycle
  typedef struct packed {
    logic step;   // sample word
    logic start;  // start-calibration word
  } imubc_ctl_t;

  typedef struct packed {
    logic calibrating;
    logic done;
  } imubc_stat_t;

endpackage

>>> hw/rtl/imubc_in_if.sv
// ----------------------------------------------------------------------------
// imubc_in_if
// Sample channel: command plus three accel and three gyro axes.
// ----------------------------------------------------------------------------
interface imubc_in_if
  import imubc_pkg::*;
;
  logic    valid;
  logic    ready;
  logic    command;
  sample_t acc_x;
  sample_t acc_y;
  sample_t acc_z;
  sample_t gyro_x;
  sample_t gyro_y;
  sample_t gyro_z;

  modport source (
    output valid, command, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z,
    input  ready
  );

  modport sink (
    input  valid, command, acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z,
    output ready
  );
endinterface

>>> hw/rtl/imubc_out_if.sv
// ----------------------------------------------------------------------------
// imubc_out_if
// Result channel: smoothed gyro, accel offsets and calibration status.
// ----------------------------------------------------------------------------
interface imubc_out_if
  import imubc_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t smooth_gyro_x;
  sample_t smooth_gyro_y;
  sample_t smooth_gyro_z;
  sample_t acc_offset_x;
  sample_t acc_offset_y;
  sample_t acc_offset_z;
  logic    calibrating;
  logic    calibration_done;

  modport source (
    output valid, smooth_gyro_x, smooth_gyro_y, smooth_gyro_z,
           acc_offset_x, acc_offset_y, acc_offset_z, calibrating, calibration_done,
    input  ready
  );

  modport sink (
    input  valid, smooth_gyro_x, smooth_gyro_y, smooth_gyro_z,
           acc_offset_x, acc_offset_y, acc_offset_z, calibrating, calibration_done,
    output ready
  );
endinterface

>>> hw/rtl/imubc_smooth.sv
// ----------------------------------------------------------------------------
// imubc_smooth
// One gyro axis: offset removal and one-pole Q16 IIR, truncated toward zero.
// ----------------------------------------------------------------------------
module imubc_smooth
  import imubc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  imubc_ctl_t        ctl,
  input  logic [KEEP_W-1:0] keep,
  input  sample_t           gyro,
  input  sample_t           offset,
  output sample_t           sm
);

  sample_t              prev_r, prev_nxt;
  sample_t              x;
  logic [KEEP_W:0]      new_w;
  logic signed [34:0]   p_old, p_new, acc_sum, acc_adj;
  sample_t              sm_new;

  always_comb begin
    x       = gyro - offset;
    new_w   = (KEEP_W+1)'(17'h10000) - {1'b0, keep};
    p_old   = 35'($signed({1'b0, keep})) * 35'(prev_r);
    p_new   = 35'($signed({1'b0, new_w})) * 35'(x);
    acc_sum = p_old + p_new;
    // bias negative sums so the shift rounds toward zero
    acc_adj = acc_sum[34] ? acc_sum + 35'sd65535 : acc_sum;
    sm_new  = acc_adj[31:16];
    sm      = ctl.start ? prev_r : sm_new;
    prev_nxt = ctl.step ? sm_new : prev_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else begin
      prev_r <= prev_nxt;
    end
  end

endmodule

>>> hw/rtl/imubc_cal.sv
// ----------------------------------------------------------------------------
// imubc_cal
// Calibration sequencer: quiet detection, discard, accumulation and offsets.
// ----------------------------------------------------------------------------
`include "imu_bias_calibration_smoother_assert.svh"

module imubc_cal
  import imubc_pkg::*;
#(
  parameter int unsigned AVERAGE_SHIFT = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  imubc_ctl_t    ctl,
  input  imubc_cfg_t    cfg,
  input  sample_t [2:0] acc,
  input  sample_t [2:0] sm,
  output sample_t [2:0] gyro_off,
  output sample_t [2:0] acc_off_nxt,
  output imubc_stat_t   stat
);

  localparam int unsigned SUM_W   = AVERAGE_SHIFT + SAMPLE_W;
  localparam int unsigned CNT_W   = (AVERAGE_SHIFT > DISCARD_W) ? AVERAGE_SHIFT : DISCARD_W;
  localparam int unsigned ACC_LEN = 1 << AVERAGE_SHIFT;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_QUIET   = 2'd1;
  localparam logic [1:0] PH_DISCARD = 2'd2;
  localparam logic [1:0] PH_ACCUM   = 2'd3;

  logic [1:0]                  phase_r, phase_nxt, phase_mid;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt, cnt_mid;
  logic [CNT_W:0]              cnt_inc;
  logic signed [SUM_W-1:0]     sums_r [6];
  logic signed [SUM_W-1:0]     sums_nxt [6];
  logic signed [SUM_W-1:0]     sums_add [6];
  logic signed [SUM_W-1:0]     addend [6];
  sample_t                     offs_r [6];
  sample_t                     offs_nxt [6];
  sample_t                     qref_r [3];
  sample_t                     qref_nxt [3];
  logic [2:0]                  in_band;
  logic [NEEDED_W-1:0]         needed_eff;
  logic signed [SAMPLE_W:0]    acc_z_g;
  logic signed [SAMPLE_W:0]    band_s;
  logic signed [SAMPLE_W:0]    delta;
  logic                        done;

  // quiet test and addends, one per axis
  always_comb begin
    band_s  = $signed({9'b0, cfg.quiet_band});
    acc_z_g = (SAMPLE_W+1)'(acc[2]) - $signed({2'b0, cfg.gravity_ref});
    for (int i = 0; i < 3; i++) begin
      delta      = (SAMPLE_W+1)'(sample_t'(sm[i] - qref_r[i]));
      in_band[i] = (delta <= band_s) && (delta >= -band_s);
    end
    addend[0] = SUM_W'(acc[0]);
    addend[1] = SUM_W'(acc[1]);
    addend[2] = SUM_W'(acc_z_g);
    for (int i = 0; i < 3; i++) begin
      addend[3+i] = SUM_W'(sm[i]);
    end
    for (int i = 0; i < 6; i++) begin
      sums_add[i] = sums_r[i] + addend[i];
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    phase_mid  = phase_r;
    cnt_mid    = cnt_r;
    sums_nxt   = sums_r;
    offs_nxt   = offs_r;
    qref_nxt   = qref_r;
    done       = 1'b0;
    cnt_inc    = {1'b0, cnt_r} + (CNT_W+1)'(1);
    needed_eff = (cfg.quiet_needed == '0) ? NEEDED_W'(1) : cfg.quiet_needed;

    if (ctl.start) begin
      for (int i = 0; i < 6; i++) begin
        sums_nxt[i] = '0;
        offs_nxt[i] = '0;
      end
      for (int i = 0; i < 3; i++) begin
        qref_nxt[i] = '0;
      end
      cnt_nxt   = '0;
      phase_nxt = PH_QUIET;
    end else if (ctl.step) begin
      unique case (phase_r)
        PH_QUIET: begin
          for (int i = 0; i < 3; i++) begin
            qref_nxt[i] = sm[i];
          end
          if (&in_band) begin
            if (cnt_inc >= (CNT_W+1)'(needed_eff)) begin
              phase_mid = PH_DISCARD;
              cnt_mid   = '0;
            end else begin
              cnt_mid = cnt_inc[CNT_W-1:0];
            end
          end
        end
        PH_DISCARD: begin
          if (cnt_r < CNT_W'(cfg.discard_count)) begin
            cnt_mid = cnt_inc[CNT_W-1:0];
          end else begin
            // discard done: this word is already summed
            phase_mid = PH_ACCUM;
            cnt_mid   = '0;
          end
        end
        default: ;
      endcase

      phase_nxt = phase_mid;
      cnt_nxt   = cnt_mid;
      if (phase_mid == PH_ACCUM) begin
        if (cnt_mid == CNT_W'(ACC_LEN - 1)) begin
          for (int i = 0; i < 6; i++) begin
            offs_nxt[i] = sums_add[i][AVERAGE_SHIFT +: SAMPLE_W];
            sums_nxt[i] = '0;
          end
          cnt_nxt   = '0;
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end else begin
          sums_nxt = sums_add;
          cnt_nxt  = cnt_mid + CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      gyro_off[i]    = offs_r[3+i];
      acc_off_nxt[i] = offs_nxt[i];
    end
    stat.calibrating = (phase_nxt != PH_IDLE);
    stat.done        = done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      for (int i = 0; i < 6; i++) begin
        sums_r[i] <= '0;
        offs_r[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        qref_r[i] <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sums_r  <= sums_nxt;
      offs_r  <= offs_nxt;
      qref_r  <= qref_nxt;
    end
  end

  `IMUBC_ASSERT_NXT(a_start_enters_quiet, clk, rst_n, ctl.start, phase_r == PH_QUIET && cnt_r == '0)
  `IMUBC_ASSERT_IMP(a_idle_count_clear, clk, rst_n, phase_r == PH_IDLE, cnt_r == '0)
  `IMUBC_ASSERT_IMP(a_accum_count_range, clk, rst_n, phase_r == PH_ACCUM, cnt_inc <= (CNT_W+1)'(ACC_LEN))
  `IMUBC_ASSERT_NXT(a_done_clears_run, clk, rst_n, done, phase_r == PH_IDLE && sums_r[0] == '0)

endmodule

>>> hw/rtl/imu_bias_calibration_smoother.sv
// ----------------------------------------------------------------------------
// imu_bias_calibration_smoother
// Gyro offset removal with IIR smoothing and quiet-period bias calibration.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one word per sample: command 0 smooths the gyro axes and
//   feeds calibration, command 1 clears all offsets and starts a new run
//   (quiet wait, discard, then 2^AVERAGE_SHIFT summed samples).
//   out_ch returns exactly one word per input word, in order: smoothed gyro,
//   current accel offsets, calibrating flag and a one-word done flag.
//   cfg_we/cfg_index/cfg_wdata write the five settings; write them only
//   while no word is in flight.
// Timing:
//   A word is held in the input register, then the offset subtract,
//   two 17x16 multiplies and the add/round of each axis land in the output
//   register once it is free; out_ch.valid rises when that register loads.
//   One word per cycle sustained while out_ch.ready stays high; the smoothed
//   value feeds back through the smoothing history register.
// Reset: synchronous rst_n returns the settings to their defaults, clears
//   offsets, sums and smoothing history, and the sequencer goes idle.
// Stall: with out_ch.ready low the output word holds and one more word is
//   still taken into the input register before in_ch.ready drops.
// ----------------------------------------------------------------------------
module imu_bias_calibration_smoother
  import imubc_pkg::*;
#(
  parameter int unsigned AVERAGE_SHIFT = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  imubc_in_if.sink              in_ch,
  imubc_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  imubc_cfg_t    cfg_r, cfg_nxt;

  logic          s1_valid_r;
  logic          s1_cmd_r;
  sample_t [2:0] s1_acc_r;
  sample_t [2:0] s1_gyro_r;
  logic          s1_move;
  logic          in_fire;

  logic          out_valid_r;
  sample_t [2:0] out_sm_r;
  sample_t [2:0] out_acc_off_r;
  imubc_stat_t   out_stat_r;

  imubc_ctl_t    ctl;
  sample_t [2:0] sm;
  sample_t [2:0] gyro_off;
  sample_t [2:0] acc_off_nxt;
  imubc_stat_t   stat;

  // settings
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SMOOTHING_KEEP: cfg_nxt.smoothing_keep = cfg_wdata[KEEP_W-1:0];
        CFG_QUIET_BAND:     cfg_nxt.quiet_band     = cfg_wdata[BAND_W-1:0];
        CFG_QUIET_NEEDED:   cfg_nxt.quiet_needed   = cfg_wdata[NEEDED_W-1:0];
        CFG_DISCARD_COUNT:  cfg_nxt.discard_count  = cfg_wdata[DISCARD_W-1:0];
        CFG_GRAVITY_REF:    cfg_nxt.gravity_ref    = cfg_wdata[GRAV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.smoothing_keep <= RST_SMOOTHING_KEEP;
      cfg_r.quiet_band     <= RST_QUIET_BAND;
      cfg_r.quiet_needed   <= RST_QUIET_NEEDED;
      cfg_r.discard_count  <= RST_DISCARD_COUNT;
      cfg_r.gravity_ref    <= RST_GRAVITY_REF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // handshake: advance the input word whenever the output register frees up
  assign s1_move     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_move;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign ctl.step  = s1_move && (s1_cmd_r == CMD_SAMPLE);
  assign ctl.start = s1_move && (s1_cmd_r == CMD_START);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r     <= in_ch.command;
      s1_acc_r[0]  <= in_ch.acc_x;
      s1_acc_r[1]  <= in_ch.acc_y;
      s1_acc_r[2]  <= in_ch.acc_z;
      s1_gyro_r[0] <= in_ch.gyro_x;
      s1_gyro_r[1] <= in_ch.gyro_y;
      s1_gyro_r[2] <= in_ch.gyro_z;
    end
    if (s1_move) begin
      out_sm_r      <= sm;
      out_acc_off_r <= acc_off_nxt;
      out_stat_r    <= stat;
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    imubc_smooth u_smooth (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .keep   (cfg_r.smoothing_keep),
      .gyro   (s1_gyro_r[a]),
      .offset (gyro_off[a]),
      .sm     (sm[a])
    );
  end

  imubc_cal #(
    .AVERAGE_SHIFT (AVERAGE_SHIFT)
  ) u_cal (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .cfg         (cfg_r),
    .acc         (s1_acc_r),
    .sm          (sm),
    .gyro_off    (gyro_off),
    .acc_off_nxt (acc_off_nxt),
    .stat        (stat)
  );

  assign out_ch.valid            = out_valid_r;
  assign out_ch.smooth_gyro_x    = out_sm_r[0];
  assign out_ch.smooth_gyro_y    = out_sm_r[1];
  assign out_ch.smooth_gyro_z    = out_sm_r[2];
  assign out_ch.acc_offset_x     = out_acc_off_r[0];
  assign out_ch.acc_offset_y     = out_acc_off_r[1];
  assign out_ch.acc_offset_z     = out_acc_off_r[2];
  assign out_ch.calibrating      = out_stat_r.calibrating;
  assign out_ch.calibration_done = out_stat_r.done;

endmodule
